FILE: sv/geo_pkg.sv
// ----------------------------------------------------------------------------
// geo_pkg
// Shared types, constants and the base-32 character table for the geohash
// encoder.
// ----------------------------------------------------------------------------
package geo_pkg;

  localparam int MAX_CHARS     = 16;
  localparam int FRACTION_BITS = 40;

  localparam int COORD_W = 49;
  localparam int PREC_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int CNT_W   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  localparam int BITS_PER_CHAR = 5;
  localparam int BIT_CNT_W     = 3;
  localparam int IDX_W         = BITS_PER_CHAR;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_CHAR - 1);

  // Half-ranges and full interval widths in fixed point.
  localparam logic [63:0] LAT_HALF64 = 64'd90 << FRACTION_BITS;
  localparam logic [63:0] LON_HALF64 = 64'd180 << FRACTION_BITS;
  localparam logic [63:0] W_LAT64    = 64'd180 << FRACTION_BITS;
  localparam logic [63:0] W_LON64    = 64'd360 << FRACTION_BITS;

  localparam logic signed [COORD_W-1:0] LAT_HI = LAT_HALF64[COORD_W-1:0];
  localparam logic signed [COORD_W-1:0] LAT_LO = -LAT_HI;
  localparam logic signed [COORD_W-1:0] LON_HI = LON_HALF64[COORD_W-1:0];
  localparam logic signed [COORD_W-1:0] LON_LO = -LON_HI;

  localparam logic [COORD_W-1:0] W_LAT = W_LAT64[COORD_W-1:0];
  localparam logic [COORD_W-1:0] W_LON = W_LON64[COORD_W-1:0];

  localparam logic [PREC_W-1:0] PREC_MAX = PREC_W'(MAX_CHARS);

  localparam logic [CHAR_W-1:0] ERR_CHAR = '0;

  // geohash base-32 alphabet, ASCII codes
  localparam logic [CHAR_W-1:0] ALPHABET [32] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BITS
  } geo_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic init;       // offset coordinates, start bisection
    logic step;       // one bisection bit
    logic push_char;  // write character into output register
    logic push_err;   // write error result into output register
    logic last;       // last flag for push_char
  } geo_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             in_ok;    // precision and coordinates in range
    logic             out_free; // output register can take a beat
    logic [CNT_W-1:0] last_idx; // precision - 1
  } geo_sts_t;

endpackage

FILE: sv/geo_ctrl.sv
// ----------------------------------------------------------------------------
// geo_ctrl
// Sequencer for the geohash encoder: input handshake, range decision,
// bit and character counting.
// ----------------------------------------------------------------------------
module geo_ctrl import geo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  geo_sts_t sts,
  output geo_cmd_t cmd
);

  geo_state_t           state_r, state_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]     char_cnt_r, char_cnt_nxt;
  logic                 is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      bit_cnt_r  <= '0;
      char_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      char_cnt_r <= char_cnt_nxt;
    end
  end

  assign is_last = (char_cnt_r == sts.last_idx);

  always_comb begin
    state_nxt    = state_r;
    bit_cnt_nxt  = bit_cnt_r;
    char_cnt_nxt = char_cnt_r;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.in_ok) begin
          if (sts.out_free) begin
            cmd.push_err = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.init     = 1'b1;
          bit_cnt_nxt  = '0;
          char_cnt_nxt = '0;
          state_nxt    = ST_BITS;
        end
      end
      ST_BITS: begin
        if (bit_cnt_r != LAST_BIT) begin
          cmd.step    = 1'b1;
          bit_cnt_nxt = bit_cnt_r + 1'b1;
        end else if (sts.out_free) begin
          cmd.step      = 1'b1;
          cmd.push_char = 1'b1;
          cmd.last      = is_last;
          bit_cnt_nxt   = '0;
          char_cnt_nxt  = char_cnt_r + 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_char && cmd.last |=> state_r == ST_IDLE)
    else $error("last character did not return controller to idle");

  a_char_on_fifth_bit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_char |-> bit_cnt_r == LAST_BIT && cmd.step)
    else $error("character pushed before five bits were made");

  a_check_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_CHECK)
    else $error("input load not followed by range check");

endmodule

FILE: sv/geo_dp.sv
// ----------------------------------------------------------------------------
// geo_dp
// Datapath for the geohash encoder: input registers, range check, shared
// bisection step (restoring division bit) and the output register.
// ----------------------------------------------------------------------------
module geo_dp import geo_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [COORD_W-1:0] in_latitude,
  input  logic signed [COORD_W-1:0] in_longitude,
  input  logic [PREC_W-1:0]         in_precision,
  input  geo_cmd_t                  cmd,
  output geo_sts_t                  sts,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         out_char_code,
  output logic                      out_last,
  output logic                      out_error
);

  logic signed [COORD_W-1:0] lat_r, lon_r;
  logic [PREC_W-1:0]         prec_r;
  logic [COORD_W-1:0]        r_lat_r, r_lon_r;
  logic                      is_lon_r;
  logic [IDX_W-2:0]          idx_r;

  logic                      out_valid_r;
  logic [CHAR_W-1:0]         out_char_r;
  logic                      out_last_r;
  logic                      out_err_r;

  logic                      lat_ok, lon_ok, prec_ok;
  logic [COORD_W-1:0]        rem_sel, wid_sel, rem_new;
  logic [COORD_W:0]          rem_dbl;
  logic [COORD_W+1:0]        diff;
  logic                      bit_val;
  logic [IDX_W-1:0]          idx_full;
  logic [PREC_W-1:0]         prec_m1;

  // range check, bounds inclusive
  assign lat_ok  = (lat_r >= LAT_LO) && (lat_r <= LAT_HI);
  assign lon_ok  = (lon_r >= LON_LO) && (lon_r <= LON_HI);
  assign prec_ok = (prec_r != '0) && (prec_r <= PREC_MAX);
  assign prec_m1 = prec_r - 1'b1;

  assign sts.in_ok    = lat_ok && lon_ok && prec_ok;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.last_idx = prec_m1[CNT_W-1:0];

  // one restoring-division step on the selected coordinate
  assign rem_sel  = is_lon_r ? r_lon_r : r_lat_r;
  assign wid_sel  = is_lon_r ? W_LON : W_LAT;
  assign rem_dbl  = {rem_sel, 1'b0};
  assign diff     = {1'b0, rem_dbl} - {2'b00, wid_sel};
  assign bit_val  = !diff[COORD_W+1];
  assign rem_new  = bit_val ? diff[COORD_W-1:0] : rem_dbl[COORD_W-1:0];
  assign idx_full = {idx_r, bit_val};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_r  <= in_latitude;
      lon_r  <= in_longitude;
      prec_r <= in_precision;
    end
    if (cmd.init) begin
      r_lat_r  <= $unsigned(lat_r + LAT_HI);
      r_lon_r  <= $unsigned(lon_r + LON_HI);
      is_lon_r <= 1'b1;
    end else if (cmd.step) begin
      if (is_lon_r) begin
        r_lon_r <= rem_new;
      end else begin
        r_lat_r <= rem_new;
      end
      is_lon_r <= !is_lon_r;
      idx_r    <= idx_full[IDX_W-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_char || cmd.push_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_char) begin
      out_char_r <= ALPHABET[idx_full];
      out_last_r <= cmd.last;
      out_err_r  <= 1'b0;
    end else if (cmd.push_err) begin
      out_char_r <= ERR_CHAR;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign out_error     = out_err_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_char || cmd.push_err) |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init && sts.in_ok |=> (r_lat_r <= W_LAT) && (r_lon_r <= W_LON))
    else $error("offset coordinate outside interval width");

endmodule

FILE: sv/geohash_encoder.sv
// ----------------------------------------------------------------------------
// geohash_encoder
// Geohash base-32 encoder: latitude/longitude in signed fixed point
// (40 fraction bits) to 1..16 geohash characters, one beat per character.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid / in_stall (out)  | in_latitude, in_longitude (s49),
//          |                            | in_precision (u8)
//  out     | out_valid / out_stall (in) | out_char_code (u7), out_last,
//          |                            | out_error
//
//  An item is handled in order: the beat is taken, then the range is checked,
//  then the bisection makes one bit per cycle through the single shared
//  compare/subtract unit when the output is not stalled.
//  A rejected item yields one error beat.
//  Synchronous active-low reset clears the sequencer and the output valid.
//  A stalled output holds the finished character; bisection pauses on the
//  fifth bit of the next character until the output register frees up.
//  The next item is taken as soon as the last character is in the output
//  register, even while that beat is still stalled.
// ----------------------------------------------------------------------------
module geohash_encoder import geo_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_latitude,
  input  logic signed [COORD_W-1:0] in_longitude,
  input  logic [PREC_W-1:0]         in_precision,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         out_char_code,
  output logic                      out_last,
  output logic                      out_error
);

  geo_cmd_t cmd;
  geo_sts_t sts;

  // sequencer: handshake, counters, decisions
  geo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: coordinates, bisection remainders, output register
  geo_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_latitude   (in_latitude),
    .in_longitude  (in_longitude),
    .in_precision  (in_precision),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_error     (out_error)
  );

endmodule
